// File: src/qph_pkg.sv
`default_nettype none

package qph_pkg;

  // Store geometry
  localparam int unsigned TableDepth = 64;
  localparam int unsigned SlotW      = $clog2(TableDepth);

  // Field widths
  localparam int unsigned KeyW   = 31;
  localparam int unsigned SizeW  = 7;
  localparam int unsigned CountW = 7;

  // Register reset and count ceiling
  localparam logic [SizeW-1:0]  SizeReset = SizeW'(11);
  localparam logic [CountW-1:0] CountMax  = {CountW{1'b1}};

  // Operation codes
  localparam logic FuncInsert = 1'b0;
  localparam logic FuncRead   = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    StInserted = 2'd0,
    StFull     = 2'd1,
    StOccupied = 2'd2,
    StEmpty    = 2'd3
  } status_e;

endpackage

`default_nettype wire

// File: src/qph_mod.sv
`default_nettype none

// Restoring remainder unit: one dividend bit per cycle.
module qph_mod import qph_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [KeyW-1:0]  dividend_i,
  input  wire logic [SizeW-1:0] divisor_i,
  output logic                  done_o,
  output logic [SizeW-1:0]      rem_o
);

  localparam int unsigned CntW = $clog2(KeyW);

  logic [KeyW-1:0]  quo_q;
  logic [SizeW-1:0] rem_q;
  logic [CntW-1:0]  cnt_q;
  logic             run_q;
  logic             done_q;
  logic [SizeW-1:0] trial;
  logic [SizeW-1:0] rem_d;

  // Shift in the next dividend bit and subtract when it fits
  assign trial = {rem_q[SizeW-2:0], quo_q[KeyW-1]};
  assign rem_d = (trial >= divisor_i) ? trial - divisor_i : trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
        rem_q <= '0;
        quo_q <= dividend_i;
      end else if (run_q) begin
        rem_q <= rem_d;
        quo_q <= {quo_q[KeyW-2:0], 1'b0};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(KeyW - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// File: src/quadratic_probe_hash_insert.sv
`default_nettype none

// Open-addressing hash table with quadratic probing.
// Command channel: present func_i, key_i and slot_select_i with start; the
// beat is taken at a rising edge where start is high and busy is low.
// busy stays high until the result has been posted.
// Result channel: status_o, slot_o, value_o and stored_count_o are valid for
// exactly one cycle while done_o is high; the receiver cannot stall them.
// Config channel: cfg_data_i sets table_size on a cfg_valid_i/cfg_ready_o
// beat; write it only while the block is idle.
// Sequence: a read passes from S_IDLE through S_READ to the result register,
// using one key-memory read. An insert computes the home slot with a bit-serial
// remainder over the key bits in S_DIV, then checks the occupancy bits probe by
// probe in S_PROBE until it places the key or reports full; one item is in
// flight at a time.
// Reset empties the table at once (occupancy bits in flops), clears the
// stored count and sets table_size to 11; the key memory is not cleared.
module quadratic_probe_hash_insert import qph_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              func_i,
  input  wire logic [KeyW-1:0]   key_i,
  input  wire logic [SlotW-1:0]  slot_select_i,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [SizeW-1:0]  cfg_data_i,
  output logic                   done_o,
  output logic [1:0]             status_o,
  output logic [SlotW-1:0]       slot_o,
  output logic [KeyW-1:0]        value_o,
  output logic [CountW-1:0]      stored_count_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DIV,
    S_PROBE
  } state_e;

  state_e            state_q;
  logic [SizeW-1:0]  table_size_q;
  logic [SizeW-1:0]  n_q;
  logic [SizeW-1:0]  n_d;
  logic [KeyW-1:0]   key_q;
  logic [SlotW-1:0]  sel_q;
  logic [SlotW-1:0]  home_q;
  logic [SlotW-1:0]  idx_q;
  logic [SizeW-1:0]  stp_q;
  logic [SizeW-1:0]  i_q;
  logic [TableDepth-1:0] used_q;
  logic [CountW-1:0] count_q;

  logic              done_q;
  status_e           status_q;
  logic [SlotW-1:0]  slot_q;
  logic [KeyW-1:0]   value_q;

  logic [KeyW-1:0]   mem_q [TableDepth];
  logic [KeyW-1:0]   rdata_q;

  logic              accept;
  logic              div_start;
  logic              div_done;
  logic [SizeW-1:0]  div_rem;
  logic              mem_we;
  logic [SizeW-1:0]  sum;
  logic [SizeW-1:0]  idx_nxt;
  logic [SizeW-1:0]  stp_sum;
  logic [SizeW-1:0]  stp_nxt;
  logic [CountW-1:0] count_inc;

  assign accept    = start && !busy;
  assign div_start = accept && (func_i == FuncInsert);

  // Clamp the modulus into 1..TableDepth
  always_comb begin
    if (table_size_q == '0) begin
      n_d = SizeW'(1);
    end else if (table_size_q > SizeW'(TableDepth)) begin
      n_d = SizeW'(TableDepth);
    end else begin
      n_d = table_size_q;
    end
  end

  // Step to the next quadratic probe: idx += 2i+1, both kept below n
  assign sum     = {1'b0, idx_q} + stp_q;
  assign idx_nxt = (sum >= n_q) ? sum - n_q : sum;
  assign stp_sum = stp_q + SizeW'(2);
  assign stp_nxt = (stp_sum >= n_q) ? stp_sum - n_q : stp_sum;

  assign count_inc = (count_q == CountMax) ? count_q : count_q + 1'b1;
  assign mem_we    = (state_q == S_PROBE) && !used_q[idx_q];

  qph_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (key_i),
    .divisor_i  (n_d),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // Key memory: write on a successful probe, read for a slot read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[idx_q] <= key_q;
    end
    if (accept) begin
      rdata_q <= mem_q[slot_select_i];
    end
  end

  // Sequencer, occupancy bits, count and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      table_size_q <= SizeReset;
      n_q          <= SizeW'(1);
      key_q        <= '0;
      sel_q        <= '0;
      home_q       <= '0;
      idx_q        <= '0;
      stp_q        <= '0;
      i_q          <= '0;
      used_q       <= '0;
      count_q      <= '0;
      done_q       <= 1'b0;
      status_q     <= StEmpty;
      slot_q       <= '0;
      value_q      <= '0;
    end else begin
      done_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        table_size_q <= cfg_data_i;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            key_q <= key_i;
            sel_q <= slot_select_i;
            n_q   <= n_d;
            state_q <= (func_i == FuncRead) ? S_READ : S_DIV;
          end
        end
        S_READ: begin
          done_q  <= 1'b1;
          slot_q  <= sel_q;
          if (used_q[sel_q]) begin
            status_q <= StOccupied;
            value_q  <= rdata_q;
          end else begin
            status_q <= StEmpty;
            value_q  <= '0;
          end
          state_q <= S_IDLE;
        end
        S_DIV: begin
          if (div_done) begin
            home_q  <= div_rem[SlotW-1:0];
            idx_q   <= div_rem[SlotW-1:0];
            stp_q   <= (n_q == SizeW'(1)) ? '0 : SizeW'(1);
            i_q     <= '0;
            state_q <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (!used_q[idx_q]) begin
            used_q[idx_q] <= 1'b1;
            count_q  <= count_inc;
            done_q   <= 1'b1;
            status_q <= StInserted;
            slot_q   <= idx_q;
            value_q  <= key_q;
            state_q  <= S_IDLE;
          end else if ((i_q + 1'b1 >= n_q) || (idx_nxt[SlotW-1:0] == home_q)) begin
            // Out of probes or wrapped to home: report full
            done_q   <= 1'b1;
            status_q <= StFull;
            slot_q   <= '0;
            value_q  <= '0;
            state_q  <= S_IDLE;
          end else begin
            idx_q <= idx_nxt[SlotW-1:0];
            stp_q <= stp_nxt;
            i_q   <= i_q + 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy           = (state_q != S_IDLE);
  assign cfg_ready_o    = !busy;
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign slot_o         = slot_q;
  assign value_o        = value_q;
  assign stored_count_o = count_q;

endmodule

`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import qph_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned DrainWait  = 100;

  // One expected result of the hash table
  typedef struct packed {
    status_e              status;
    logic [SlotW-1:0]     slot;
    logic [KeyW-1:0]      value;
    logic [CountW-1:0]    count;
  } table_reply_t;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              start          = 1'b0;
  logic              busy;
  logic              func_i         = FuncInsert;
  logic [KeyW-1:0]   key_i          = '0;
  logic [SlotW-1:0]  slot_select_i  = '0;
  logic              cfg_valid_i    = 1'b0;
  logic              cfg_ready_o;
  logic [SizeW-1:0]  cfg_data_i     = '0;
  logic              done_o;
  logic [1:0]        status_o;
  logic [SlotW-1:0]  slot_o;
  logic [KeyW-1:0]   value_o;
  logic [CountW-1:0] stored_count_o;

  // Shadow copy of the table and its register
  logic [KeyW-1:0]   shadow_keys [TableDepth];
  logic              shadow_used [TableDepth];
  logic [CountW-1:0] shadow_count;
  logic [SizeW-1:0]  shadow_size;

  table_reply_t      table_replies_due[$];
  table_reply_t      due;

  int unsigned n_fail     = 0;
  int unsigned n_items    = 0;
  int unsigned n_inserted = 0;
  int unsigned n_full     = 0;
  int unsigned n_occupied = 0;
  int unsigned n_empty    = 0;
  int unsigned n_sizes    = 0;
  int unsigned cycles     = 0;
  int unsigned burst_left = 0;
  bit          gaps_on    = 1'b1;

  quadratic_probe_hash_insert i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .key_i          (key_i),
    .slot_select_i  (slot_select_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .slot_o         (slot_o),
    .value_o        (value_o),
    .stored_count_o (stored_count_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("FAIL quadratic_probe_hash_insert");
      $finish;
    end
  end

  // Apply one accepted beat to the shadow table and queue its result
  function automatic void predict_table_op(logic f, logic [KeyW-1:0] k,
                                           logic [SlotW-1:0] sel);
    table_reply_t r;
    int unsigned  n;
    int unsigned  home;
    int unsigned  idx;
    bit           placed;
    if (f == FuncRead) begin
      if (shadow_used[sel]) begin
        r = '{status: StOccupied, slot: sel, value: shadow_keys[sel], count: shadow_count};
      end else begin
        r = '{status: StEmpty, slot: sel, value: '0, count: shadow_count};
      end
    end else begin
      // Out-of-range sizes clamp to 1 and to the store depth
      n = (shadow_size == 0) ? 1 : ((shadow_size > TableDepth) ? TableDepth : shadow_size);
      home = k % n;
      idx = home;
      placed = !shadow_used[home];
      if (!placed) begin
        for (int unsigned i = 1; i < n; i++) begin
          idx = (home + i * i) % n;
          // Probe wrapped onto home: give up
          if (idx == home) break;
          if (!shadow_used[idx]) begin
            placed = 1'b1;
            break;
          end
        end
      end
      if (placed) begin
        shadow_keys[idx] = k;
        shadow_used[idx] = 1'b1;
        if (shadow_count < CountMax) shadow_count++;
        r = '{status: StInserted, slot: idx[SlotW-1:0], value: k, count: shadow_count};
      end else begin
        r = '{status: StFull, slot: '0, value: '0, count: shadow_count};
      end
    end
    table_replies_due.push_back(r);
  endfunction

  // Check each result beat against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (table_replies_due.size() == 0) begin
        $error("unexpected result beat: status %0d slot %0d value %0d", status_o, slot_o,
               value_o);
        n_fail++;
      end else begin
        due = table_replies_due.pop_front();
        case (due.status)
          StInserted: n_inserted++;
          StFull:     n_full++;
          StOccupied: n_occupied++;
          default:    n_empty++;
        endcase
        if (status_o !== due.status) begin
          $error("status: expected %0d, actual %0d", due.status, status_o);
          n_fail++;
        end
        if (slot_o !== due.slot) begin
          $error("slot: expected %0d, actual %0d", due.slot, slot_o);
          n_fail++;
        end
        if (value_o !== due.value) begin
          $error("value: expected %0d, actual %0d", due.value, value_o);
          n_fail++;
        end
        if (stored_count_o !== due.count) begin
          $error("stored_count: expected %0d, actual %0d", due.count, stored_count_o);
          n_fail++;
        end
      end
    end
  end

  // Send one command beat; gaps fall between bursts
  task automatic send_item(input logic f, input logic [KeyW-1:0] k,
                           input logic [SlotW-1:0] sel);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    start         <= 1'b1;
    func_i        <= f;
    key_i         <= k;
    slot_select_i <= sel;
    do @(posedge clk_i); while (busy);
    predict_table_op(f, k, sel);
    n_items++;
  endtask

  // Drop start and hold until every result is back
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk_i); while (table_replies_due.size() != 0 || busy);
    burst_left = 0;
  endtask

  task automatic write_table_size(input logic [SizeW-1:0] sz);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= sz;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    shadow_size = sz;
    n_sizes++;
  endtask

  // Home hits, collisions and key extremes at the reset size
  task automatic test_directed_inserts();
    send_item(FuncInsert, '0, '0);
    send_item(FuncInsert, KeyW'(11), '1);
    send_item(FuncInsert, KeyW'(22), '0);
    send_item(FuncInsert, '1, '0);
    send_item(FuncInsert, KeyW'(32'h2AAA_AAAA), '1);
    send_item(FuncInsert, KeyW'(32'h5555_5555), '0);
  endtask

  // Occupied slots, empty slots and the top slot
  task automatic test_read_slots();
    send_item(FuncRead, '1, SlotW'(0));
    send_item(FuncRead, '0, SlotW'(1));
    send_item(FuncRead, '1, SlotW'(4));
    send_item(FuncRead, '0, SlotW'(9));
    send_item(FuncRead, '0, SlotW'(10));
    send_item(FuncRead, '1, SlotW'(63));
  endtask

  // Clamped sizes, probe wrapping home and a fully probed small table
  task automatic test_size_extremes();
    write_table_size(SizeW'(1));
    send_item(FuncInsert, KeyW'(5), '0);
    write_table_size(SizeW'(0));
    send_item(FuncInsert, '0, '0);
    write_table_size('1);
    send_item(FuncInsert, KeyW'(127), '0);
    send_item(FuncInsert, KeyW'(127), '0);
    send_item(FuncRead, '0, SlotW'(63));
    write_table_size(SizeW'(4));
    send_item(FuncInsert, KeyW'(0), '0);
    send_item(FuncInsert, KeyW'(3), '0);
    send_item(FuncInsert, KeyW'(3), '0);
    write_table_size(SizeW'(2));
    send_item(FuncInsert, KeyW'(1), '0);
  endtask

  // Let the block drain completely in mid stream
  task automatic test_drain_pause();
    send_item(FuncRead, '0, SlotW'(3));
    send_item(FuncInsert, KeyW'(2), '0);
    wait_idle();
    send_item(FuncRead, '0, SlotW'(2));
  endtask

  // Random traffic while the table size grows step by step, then drops back to 6
  task automatic test_probe_phases();
    int unsigned       phase_sizes[21] = '{2, 3, 4, 5, 7, 8, 9, 12, 16, 17, 23, 31, 32, 41,
                                           48, 53, 63, 64, 100, 127, 6};
    int unsigned       eff;
    logic [KeyW-1:0]   k;
    logic [SlotW-1:0]  sel;
    foreach (phase_sizes[p]) begin
      write_table_size(SizeW'(phase_sizes[p]));
      eff = (phase_sizes[p] > TableDepth) ? TableDepth : phase_sizes[p];
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat (29) begin
        case ($urandom_range(0, 7))
          0, 1:    k = KeyW'($urandom_range(0, 200));
          2:       k = '1 - KeyW'($urandom_range(0, 200));
          default: k = KeyW'($urandom);
        endcase
        sel = ($urandom_range(0, 1) != 0) ? SlotW'($urandom_range(0, eff - 1))
                                          : SlotW'($urandom);
        if ($urandom_range(0, 99) < 65) send_item(FuncInsert, k, sel);
        else send_item(FuncRead, k, sel);
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    foreach (shadow_used[i]) begin
      shadow_used[i] = 1'b0;
      shadow_keys[i] = '0;
    end
    shadow_count = '0;
    shadow_size  = SizeReset;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_inserts();
    test_read_slots();
    test_size_extremes();
    test_drain_pause();
    test_probe_phases();

    wait_idle();
    repeat (DrainWait) @(posedge clk_i);

    $display("Sent %0d commands over %0d table sizes in %0d cycles", n_items, n_sizes, cycles);
    $display("Results: %0d inserted, %0d full, %0d occupied reads, %0d empty reads",
             n_inserted, n_full, n_occupied, n_empty);
    if (n_fail == 0) begin
      $display("PASS quadratic_probe_hash_insert");
    end else begin
      $display("FAIL quadratic_probe_hash_insert");
    end
    $finish;
  end

endmodule
